// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define PCS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// same, checked through reset as well
`define PCS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/core/pcs_pkg.sv -----
`default_nettype none
package pcs_pkg;

	typedef struct packed {
		logic        action;
		logic [31:0] client_key;
		logic [7:0]  pulse;
		logic [31:0] sample_time;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_index;
		logic [7:0]  pulse_echo;
		logic [15:0] sample_count;
		logic [7:0]  pulse_max;
		logic [7:0]  pulse_min;
		logic [15:0] pulse_average;
		logic [3:0]  bin_index;
		logic [15:0] bin_count;
	} result_t;

	typedef struct packed {
		logic [31:0] window_start;
		logic [31:0] last_time;
		logic [15:0] count;
		logic [23:0] sum;
		logic [7:0]  max;
		logic [7:0]  min;
	} stats_t;

	typedef enum logic [3:0] {
		S_IDLE, S_KRD, S_KCMP, S_SRD, S_SCHK, S_HCLR, S_HRD, S_HWR, S_DIV, S_OUT
	} state_t;

	localparam logic [1:0] ST_WARN   = 2'd0;
	localparam logic [1:0] ST_NORMAL = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic [1:0] CFG_LOW    = 2'd0;
	localparam logic [1:0] CFG_HIGH   = 2'd1;
	localparam logic [1:0] CFG_WINDOW = 2'd2;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_EXIT   = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/core/pcs_ram.sv -----
`default_nettype none
module pcs_ram #(
	parameter int DEPTH = 10,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// ----- rtl/core/pcs_divider.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle
module pcs_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] div_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [16:0] remsh;
	logic        fits;

	assign remsh = {rem_q, quo_q[31]};
	assign fits  = remsh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? 16'(remsh - {1'b0, div_q}) : remsh[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ----- rtl/core/per_client_pulse_statistics.sv -----
`default_nettype none
// Per-client pulse statistics.
// Input: pulse a start with the item while busy is low; the transfer happens at that edge.
// An item is either a pulse sample or a client exit, tagged with a 32-bit client key.
// A sample gives one result on the result port, marked by result_valid for a single
// cycle; an exit gives none. The receiver takes every result and cannot stall.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 low limit, 1 high limit,
// 2 window length) and cfg_data; write only while busy is low.
// One item at a time. Key search walks the key memory slot by slot, a read and then
// a compare for each, and stops at a match. A sample then goes through the stats read,
// the stats check and write, a clear of the slot's BINS histogram bins when the window
// restarts or the slot is new, the histogram read and write, the bit-serial divider for
// the mean and the result state, with result_valid in the last busy cycle. A table-full
// sample gives its result right after the search. An exit ends after the search. The
// next start is taken in the cycle after busy falls.
// Reset clears slot ownership and activity flags and loads the default limits;
// the memories need no clearing pass since a slot's histogram is swept on its
// first sample.
module per_client_pulse_statistics #(
	parameter int SLOTS     = 10,
	parameter int BINS      = 10,
	parameter int BIN_WIDTH = 20
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire pcs_pkg::item_t  item,
	output logic                 result_valid,
	output pcs_pkg::result_t     result,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [31:0]     cfg_data
);
	import pcs_pkg::*;

	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BW  = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int HD  = SLOTS * BINS;
	localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
	localparam int SBW = $bits(stats_t);

	state_t state_q, state_d;

	item_t         item_q;
	logic [7:0]    low_q, high_q;
	logic [31:0]   wl_q;
	logic [SLOTS-1:0] used_q, active_q;
	logic [SW-1:0] scan_q, slot_q, free_q;
	logic          free_found_q, full_q;
	logic [HAW-1:0] base_q;
	logic [BW-1:0] hclr_q, bin_q;
	logic          fresh_q;
	logic [15:0]   count_q, bincnt_q;
	logic [23:0]   sum_q;
	logic [7:0]    max_q, min_q;

	logic [31:0]   key_rd;
	stats_t        st_rd, st_new;
	logic [15:0]   hist_rd;
	logic          key_we, st_we, hist_we;
	logic [SW-1:0] key_waddr, key_raddr;
	logic [HAW-1:0] hist_addr;
	logic [15:0]   hist_wdata;
	logic          div_start, div_done;
	logic [31:0]   quotient;

	logic          match, last_slot, free_avail, fresh;
	logic [SW-1:0] alloc_slot;
	logic [15:0]   cnt0;
	logic [23:0]   sum0;
	logic [BW-1:0] bin_calc;

	assign match      = used_q[scan_q] && (key_rd == item_q.client_key);
	assign last_slot  = scan_q == SW'(SLOTS - 1);
	assign free_avail = free_found_q || !used_q[scan_q];
	assign alloc_slot = free_found_q ? free_q : scan_q;
	assign fresh      = !active_q[slot_q]
		|| (wl_q <= 32'(st_rd.last_time - st_rd.window_start));

	// bin = min(pulse / BIN_WIDTH, BINS-1) by threshold compares
	always_comb begin
		bin_calc = '0;
		for (int b = 1; b < BINS; b++) begin
			if ({2'b0, item_q.pulse} >= 10'(b * BIN_WIDTH) || b * BIN_WIDTH > 255) begin
				if (b * BIN_WIDTH <= 255) begin
					bin_calc = BW'(b);
				end
			end
		end
	end

	always_comb begin
		cnt0   = fresh ? 16'd0 : st_rd.count;
		sum0   = fresh ? 24'd0 : st_rd.sum;
		st_new = st_rd;
		st_new.last_time = item_q.sample_time;
		if (cnt0 != 16'hFFFF) begin
			st_new.count = cnt0 + 16'd1;
			st_new.sum   = sum0 + {16'd0, item_q.pulse};
		end else begin
			st_new.count = cnt0;
			st_new.sum   = sum0;
		end
		if (fresh) begin
			st_new.window_start = item_q.sample_time;
			st_new.max = item_q.pulse;
			st_new.min = item_q.pulse;
		end else begin
			st_new.max = (item_q.pulse > st_rd.max) ? item_q.pulse : st_rd.max;
			st_new.min = (item_q.pulse < st_rd.min) ? item_q.pulse : st_rd.min;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_KRD;
			S_KRD:  state_d = S_KCMP;
			S_KCMP: begin
				if (match) begin
					state_d = (item_q.action == ACT_EXIT) ? S_IDLE : S_SRD;
				end else if (last_slot) begin
					if (item_q.action == ACT_EXIT) state_d = S_IDLE;
					else state_d = free_avail ? S_SRD : S_OUT;
				end else begin
					state_d = S_KRD;
				end
			end
			S_SRD:  state_d = S_SCHK;
			S_SCHK: state_d = fresh ? S_HCLR : S_HRD;
			S_HCLR: if (hclr_q == BW'(BINS - 1)) state_d = S_HRD;
			S_HRD:  state_d = S_HWR;
			S_HWR:  state_d = S_DIV;
			S_DIV:  if (div_done) state_d = S_OUT;
			S_OUT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		busy       = state_q != S_IDLE;
		key_raddr  = scan_q;
		key_we     = 1'b0;
		key_waddr  = alloc_slot;
		st_we      = 1'b0;
		hist_we    = 1'b0;
		hist_addr  = HAW'(base_q + HAW'(bin_q));
		hist_wdata = (hist_rd == 16'hFFFF) ? hist_rd : hist_rd + 16'd1;
		div_start  = 1'b0;
		unique case (state_q)
			S_KCMP: key_we = !match && last_slot && item_q.action == ACT_SAMPLE && free_avail;
			S_SCHK: st_we = 1'b1;
			S_HCLR: begin
				hist_we    = 1'b1;
				hist_addr  = HAW'(base_q + HAW'(hclr_q));
				hist_wdata = '0;
			end
			S_HWR: begin
				hist_we   = 1'b1;
				div_start = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			active_q <= '0;
			low_q    <= 8'd50;
			high_q   <= 8'd120;
			wl_q     <= 32'd60;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LOW:    low_q  <= cfg_data[7:0];
					CFG_HIGH:   high_q <= cfg_data[7:0];
					CFG_WINDOW: wl_q   <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_KCMP && match && item_q.action == ACT_EXIT) begin
				used_q[scan_q]   <= 1'b0;
				active_q[scan_q] <= 1'b0;
			end
			if (key_we) begin
				used_q[alloc_slot] <= 1'b1;
			end
			if (st_we) begin
				active_q[slot_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				item_q       <= item;
				scan_q       <= '0;
				free_found_q <= 1'b0;
				full_q       <= 1'b0;
			end
			S_KCMP: begin
				if (!used_q[scan_q] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= scan_q;
				end
				if (match) begin
					slot_q <= scan_q;
				end else if (last_slot) begin
					slot_q <= alloc_slot;
					full_q <= !free_avail;
				end else begin
					scan_q <= scan_q + SW'(1);
				end
			end
			S_SRD: begin
				base_q <= HAW'(HAW'(slot_q) * HAW'(BINS));
				bin_q  <= bin_calc;
				hclr_q <= '0;
			end
			S_SCHK: begin
				fresh_q <= fresh;
				count_q <= st_new.count;
				sum_q   <= st_new.sum;
				max_q   <= st_new.max;
				min_q   <= st_new.min;
			end
			S_HCLR: hclr_q <= hclr_q + BW'(1);
			S_HWR:  bincnt_q <= hist_wdata;
			default: ;
		endcase
	end

	pcs_ram #(.DEPTH(SLOTS), .WIDTH(32), .AW(SW)) u_key_mem (
		.clk(clk), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(item_q.client_key),
		.rd_addr(key_raddr), .rd_data(key_rd)
	);

	pcs_ram #(.DEPTH(SLOTS), .WIDTH(SBW), .AW(SW)) u_stats_mem (
		.clk(clk), .wr_en(st_we), .wr_addr(slot_q), .wr_data(st_new),
		.rd_addr(slot_q), .rd_data(st_rd)
	);

	pcs_ram #(.DEPTH(HD), .WIDTH(16), .AW(HAW)) u_hist_mem (
		.clk(clk), .wr_en(hist_we), .wr_addr(hist_addr), .wr_data(hist_wdata),
		.rd_addr(hist_addr), .rd_data(hist_rd)
	);

	pcs_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({sum_q, 8'd0}), .divisor(count_q),
		.done(div_done), .quotient(quotient)
	);

	always_comb begin
		result_valid = state_q == S_OUT;
		result       = '0;
		result.pulse_echo = item_q.pulse;
		if (full_q) begin
			result.status = ST_FULL;
		end else begin
			result.status = (item_q.pulse >= low_q && item_q.pulse < high_q) ? ST_NORMAL
				: ST_WARN;
			result.slot_index    = 4'(slot_q);
			result.sample_count  = count_q;
			result.pulse_max     = max_q;
			result.pulse_min     = min_q;
			result.pulse_average = (quotient > 32'hFFFF) ? 16'hFFFF : quotient[15:0];
			result.bin_index     = 4'(bin_q);
			result.bin_count     = bincnt_q;
		end
	end

	assign cfg_ready = 1'b1;

	`include "assert_macros.svh"

	`PCS_ASSERT(a_result_busy, result_valid |-> busy, "result outside an item")
	`PCS_ASSERT(a_result_ends, result_valid |=> !busy, "result not last step of item")
	`PCS_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted item not started")
	`PCS_ASSERT(a_count_nonzero,
		(result_valid && result.status != ST_FULL) |-> result.sample_count != 16'd0,
		"sample result with zero count")
	`PCS_ASSERT_ALWAYS(a_fresh_clear, (state_q == S_HRD && $past(state_q) == S_SCHK) |-> !fresh_q,
		"histogram not cleared on fresh window")

endmodule
`default_nettype wire

// ----- verif/tb_per_client_pulse_statistics.sv -----
`timescale 1ns / 100ps
`default_nettype none
import pcs_pkg::*;

class pulse_stats_scoreboard;
	localparam int NSLOT = 10;
	localparam int NBIN = 10;
	localparam int BWID = 20;
	bit [7:0] low_lim, high_lim;
	bit [31:0] win_len;
	bit used [NSLOT];
	bit [31:0] key_of [NSLOT];
	bit active [NSLOT];
	bit [31:0] win_start [NSLOT];
	bit [31:0] last_t [NSLOT];
	bit [15:0] cnt [NSLOT];
	bit [23:0] sum [NSLOT];
	bit [7:0] pmax [NSLOT];
	bit [7:0] pmin [NSLOT];
	bit [15:0] hist [NSLOT*NBIN];
	result_t pending [$];
	int errors;

	function new();
		low_lim = 50;
		high_lim = 120;
		win_len = 60;
		errors = 0;
		for (int s = 0; s < NSLOT; s++) begin
			used[s] = 0;
			key_of[s] = 0;
			wipe(s);
		end
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] d);
		case (idx)
			CFG_LOW: low_lim = d[7:0];
			CFG_HIGH: high_lim = d[7:0];
			CFG_WINDOW: win_len = d;
			default: ;
		endcase
	endfunction

	function void wipe(int s);
		active[s] = 0;
		win_start[s] = 0;
		last_t[s] = 0;
		cnt[s] = 0;
		sum[s] = 0;
		pmax[s] = 0;
		pmin[s] = 0;
		for (int b = 0; b < NBIN; b++) hist[s*NBIN+b] = 0;
	endfunction

	function void note_item(item_t it);
		int s;
		int bin;
		bit [39:0] avg;
		result_t r;
		s = -1;
		for (int k = 0; k < NSLOT; k++)
			if (s < 0 && used[k] && key_of[k] == it.client_key) s = k;
		if (it.action == ACT_EXIT) begin
			if (s >= 0) begin
				wipe(s);
				used[s] = 0;
				key_of[s] = 0;
			end
			return;
		end
		if (s < 0) begin
			for (int k = 0; k < NSLOT; k++)
				if (s < 0 && !used[k]) s = k;
			if (s < 0) begin
				r = '0;
				r.status = ST_FULL;
				r.pulse_echo = it.pulse;
				pending.push_back(r);
				return;
			end
			used[s] = 1;
			key_of[s] = it.client_key;
		end
		if (active[s] && win_len <= 32'(last_t[s] - win_start[s])) wipe(s);
		last_t[s] = it.sample_time;
		if (cnt[s] < 16'hFFFF) begin
			cnt[s]++;
			sum[s] += it.pulse;
		end
		if (!active[s]) begin
			pmax[s] = it.pulse;
			pmin[s] = it.pulse;
			win_start[s] = it.sample_time;
			active[s] = 1;
		end else begin
			if (it.pulse > pmax[s]) pmax[s] = it.pulse;
			if (it.pulse < pmin[s]) pmin[s] = it.pulse;
		end
		avg = ({16'd0, sum[s]} << 8) / cnt[s];
		if (avg > 40'hFFFF) avg = 40'hFFFF;
		bin = it.pulse / BWID;
		if (bin > NBIN - 1) bin = NBIN - 1;
		if (hist[s*NBIN+bin] < 16'hFFFF) hist[s*NBIN+bin]++;
		r.status = (it.pulse < low_lim) ? ST_WARN :
			(it.pulse < high_lim) ? ST_NORMAL : ST_WARN;
		r.slot_index = 4'(s);
		r.pulse_echo = it.pulse;
		r.sample_count = cnt[s];
		r.pulse_max = pmax[s];
		r.pulse_min = pmin[s];
		r.pulse_average = avg[15:0];
		r.bin_index = 4'(bin);
		r.bin_count = hist[s*NBIN+bin];
		pending.push_back(r);
	endfunction

	function void check_result(result_t got);
		result_t e;
		if (pending.size() == 0) begin
			$error("unexpected result %h", got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.status !== e.status) begin
			$error("status exp %0d got %0d", e.status, got.status); errors++; end
		if (got.slot_index !== e.slot_index) begin
			$error("slot_index exp %0d got %0d", e.slot_index, got.slot_index); errors++; end
		if (got.pulse_echo !== e.pulse_echo) begin
			$error("pulse_echo exp %0d got %0d", e.pulse_echo, got.pulse_echo); errors++; end
		if (got.sample_count !== e.sample_count) begin
			$error("sample_count exp %0d got %0d", e.sample_count, got.sample_count);
			errors++; end
		if (got.pulse_max !== e.pulse_max) begin
			$error("pulse_max exp %0d got %0d", e.pulse_max, got.pulse_max); errors++; end
		if (got.pulse_min !== e.pulse_min) begin
			$error("pulse_min exp %0d got %0d", e.pulse_min, got.pulse_min); errors++; end
		if (got.pulse_average !== e.pulse_average) begin
			$error("pulse_average exp %0d got %0d", e.pulse_average, got.pulse_average);
			errors++; end
		if (got.bin_index !== e.bin_index) begin
			$error("bin_index exp %0d got %0d", e.bin_index, got.bin_index); errors++; end
		if (got.bin_count !== e.bin_count) begin
			$error("bin_count exp %0d got %0d", e.bin_count, got.bin_count); errors++; end
	endfunction
endclass

module tb_per_client_pulse_statistics;
	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	item_t item = '0;
	logic result_valid;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int unsigned cycles = 0;
	bit [31:0] key_pool [16];
	bit [31:0] clock_now = 0;
	pulse_stats_scoreboard stats = new();

	per_client_pulse_statistics DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_valid) stats.check_result(result);
		if (cycles > 2000000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic idle_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	task automatic send(logic act, logic [31:0] key, logic [7:0] p, logic [31:0] t);
		@(negedge clk);
		start <= 1;
		item <= '{action: act, client_key: key, pulse: p, sample_time: t};
		@(posedge clk);
		while (busy) @(posedge clk);
		stats.note_item('{action: act, client_key: key, pulse: p, sample_time: t});
		@(negedge clk);
		start <= 0;
		if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(0, 16));
	endtask

	task automatic drain();
		while (stats.pending.size() != 0) @(posedge clk);
		idle_cycles(80);  // an exit ends without a result
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		stats.set_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic sample_of(int k, logic [7:0] p);
		clock_now += $urandom_range(0, 30);
		send(ACT_SAMPLE, key_pool[k], p, clock_now);
	endtask

	task automatic random_phase(int n, int nkeys);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, nkeys - 1);
			case ($urandom_range(0, 19))
				0, 1: send(ACT_EXIT, key_pool[k], 8'($urandom), $urandom);
				2: send(ACT_EXIT, $urandom, 8'($urandom), $urandom);
				3: send(ACT_SAMPLE, $urandom, 8'($urandom), $urandom);
				4: send(ACT_SAMPLE, key_pool[k], 8'($urandom), $urandom);
				default: sample_of(k, 8'($urandom_range(0, 1) ? $urandom
					: $urandom_range(40, 140)));
			endcase
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (5) @(negedge clk);
		arst_n <= 1;
		idle_cycles(2);
		// directed: extremes, limits, new slots, full table, exits
		send(ACT_SAMPLE, key_pool[0], 8'd0, 32'd0);
		send(ACT_SAMPLE, key_pool[0], 8'd255, 32'd10);
		send(ACT_SAMPLE, key_pool[0], 8'd49, 32'd20);
		send(ACT_SAMPLE, key_pool[0], 8'd50, 32'd30);
		send(ACT_SAMPLE, key_pool[0], 8'd119, 32'd70);
		send(ACT_SAMPLE, key_pool[0], 8'd120, 32'd80);  // window restarts here
		for (int k = 1; k < 10; k++) send(ACT_SAMPLE, key_pool[k], 8'd199, 32'hFFFF_FFF0);
		send(ACT_SAMPLE, key_pool[1], 8'd200, 32'd5);    // wrapped time
		send(ACT_SAMPLE, key_pool[12], 8'd80, 32'd1);    // table full
		send(ACT_EXIT, key_pool[13], 8'd0, 32'd0);       // unknown exit
		send(ACT_EXIT, key_pool[4], 8'd0, 32'd0);
		send(ACT_SAMPLE, key_pool[12], 8'd100, 32'd2);   // reuses freed slot
		send(ACT_SAMPLE, key_pool[12], 8'd101, 32'd3);
		drain();
		for (int k = 0; k < 16; k++) send(ACT_EXIT, key_pool[k], 8'd0, 32'd0);
		drain();
		// crossed limits, window zero
		write_reg(CFG_LOW, 32'hFF);
		write_reg(CFG_HIGH, 32'h0);
		write_reg(CFG_WINDOW, 32'h0);
		clock_now = 0;
		random_phase(200, 6);
		drain();
		// window never expires
		write_reg(CFG_LOW, 32'h0);
		write_reg(CFG_HIGH, 32'hFF);
		write_reg(CFG_WINDOW, 32'hFFFF_FFFF);
		random_phase(400, 12);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_LOW, $urandom);
			write_reg(CFG_HIGH, $urandom);
			write_reg(CFG_WINDOW, $urandom_range(0, 200));
			random_phase(250, $urandom_range(4, 14));
			drain();
		end
		if (stats.errors == 0 && stats.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
